// ===== src/nnt_pkg.sv =====
// Shared types and constants for the nearest-neighbor tour block.
// Holds the item structs, the controller state type and the command/status structs.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package nnt_pkg;

    // Coordinate width is fixed by the item format.
    localparam int COORD_W = 16;
    // Width of the city index carried in a result item.
    localparam int CITY_W = 10;
    // Default depth of the point store.
    localparam int DEFAULT_MAX_POINTS = 1024;

    // Action codes of an input item.
    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_REQUEST = 1'b1;

    typedef struct packed {
        logic                      action;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic                      final_point;
    } in_item_t;

    typedef struct packed {
        logic [CITY_W-1:0] city;
        logic              tour_end;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // store the point of the accepted item
        logic first_sel;  // select city 0 as the next city
        logic scan_clear; // forget the best candidate before a scan
        logic rd_en;      // read one store entry for the scan
        logic emit;       // commit the best city and issue the result
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic req_ok;     // a request would produce a city
        logic first_req;  // no city of this tour has been given yet
        logic pipe_busy;  // distance pipeline still holds candidates
        logic out_free;   // result register can take a new item
    } dp_status_t;

endpackage

// ===== src/nearest_neighbor_tour.sv =====
// Nearest-neighbor tour builder. A load item is never stalled while idle. The first request
// of a tour selects city 0 and commits it from the emit state, without a scan; every later
// request scans the point store, one entry per cycle through a single read port, drains the
// distance pipeline and commits the nearest unvisited city. No new item is taken until the
// result has entered the result register, which waits while the output stalls.
// Reset clears the set, the tour progress and the handshakes; the store is not cleared.
`timescale 1ns / 1ps

module nearest_neighbor_tour #(
    parameter int MAX_POINTS = nnt_pkg::DEFAULT_MAX_POINTS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  nnt_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_stall,
    output nnt_pkg::out_item_t result
);
    import nnt_pkg::*;

    // Store addresses and the point count, which must also hold the depth itself.
    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    dp_cmd_t          cmd;
    dp_status_t       status;
    logic [IDX_W-1:0] rd_addr;
    logic [CNT_W-1:0] point_count;

    // The controller accepts items only in its idle state. A load is handled at once;
    // a request that can produce a city either commits city 0 directly or starts a scan
    // over all loaded points. A finished result waits in the datapath's result register,
    // so loads can go on while the downstream side stalls.
    nnt_ctrl #(
        .MAX_POINTS (MAX_POINTS),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .action      (item.action),
        .item_stall  (item_stall),
        .status      (status),
        .point_count (point_count),
        .cmd         (cmd),
        .rd_addr     (rd_addr)
    );

    // The datapath holds the point store with a visited mark in each entry. Loading a
    // point clears its mark, so only entries of the current set are ever read. The
    // scan pipeline reads an entry, forms absolute differences, squares them and
    // keeps the strictly smallest sum, which gives ties to the lowest index.
    nnt_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .rd_addr      (rd_addr),
        .item         (item),
        .result_stall (result_stall),
        .status       (status),
        .point_count  (point_count),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// ===== src/nnt_ctrl.sv =====
// Controller of the nearest-neighbor tour block: state machine and scan counter.
// Drives datapath commands from the input handshake and datapath status.
// Depends on nnt_pkg.
`timescale 1ns / 1ps

module nnt_ctrl #(
    parameter int MAX_POINTS = nnt_pkg::DEFAULT_MAX_POINTS,
    parameter int IDX_W      = $clog2(MAX_POINTS),
    parameter int CNT_W      = $clog2(MAX_POINTS + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  logic                 action,
    output logic                 item_stall,
    input  nnt_pkg::dp_status_t  status,
    input  logic [CNT_W-1:0]     point_count,
    output nnt_pkg::dp_cmd_t     cmd,
    output logic [IDX_W-1:0]     rd_addr
);
    import nnt_pkg::*;

    ctrl_state_t      state_reg;
    ctrl_state_t      state_next;
    logic [CNT_W-1:0] scan_cnt_reg;
    logic [CNT_W-1:0] scan_cnt_next;
    logic [CNT_W-1:0] scan_cnt_inc;

    assign scan_cnt_inc = scan_cnt_reg + 1'b1;
    assign rd_addr      = scan_cnt_reg[IDX_W-1:0];
    assign item_stall   = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            scan_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        cmd           = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    if (action == ACT_LOAD)
                    begin
                        cmd.load = 1'b1;
                    end
                    else if (status.req_ok)
                    begin
                        if (status.first_req)
                        begin
                            cmd.first_sel = 1'b1;
                            state_next    = ST_EMIT;
                        end
                        else
                        begin
                            cmd.scan_clear = 1'b1;
                            scan_cnt_next  = '0;
                            state_next     = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.rd_en     = 1'b1;
                scan_cnt_next = scan_cnt_inc;
                if (scan_cnt_inc == point_count)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/nnt_datapath.sv =====
// Datapath of the nearest-neighbor tour block: point store, distance pipeline,
// best-candidate tracking, tour bookkeeping and the result register.
// Depends on nnt_pkg; commanded by nnt_ctrl.
`timescale 1ns / 1ps

module nnt_datapath #(
    parameter int MAX_POINTS = nnt_pkg::DEFAULT_MAX_POINTS,
    parameter int IDX_W      = $clog2(MAX_POINTS),
    parameter int CNT_W      = $clog2(MAX_POINTS + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  nnt_pkg::dp_cmd_t     cmd,
    input  logic [IDX_W-1:0]     rd_addr,
    input  nnt_pkg::in_item_t    item,
    input  logic                 result_stall,
    output nnt_pkg::dp_status_t  status,
    output logic [CNT_W-1:0]     point_count,
    output logic                 result_valid,
    output nnt_pkg::out_item_t   result
);
    import nnt_pkg::*;

    localparam int SQ_W   = 2 * COORD_W;
    localparam int DIST_W = SQ_W + 1;
    localparam int MEM_W  = 2 * COORD_W + 1;

    // Absolute difference of two coordinates; it always fits in COORD_W bits.
    function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                    input logic [COORD_W-1:0] b);
        logic [COORD_W:0] d;
        logic [COORD_W:0] m;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        m = d[COORD_W] ? (~d + 1'b1) : d;
        return m[COORD_W-1:0];
    endfunction

    // Store entry: visited mark, x, y.
    logic [MEM_W-1:0] mem [MAX_POINTS];

    logic [CNT_W-1:0]   point_count_reg;
    logic [CNT_W-1:0]   emitted_reg;
    logic               set_complete_reg;
    logic [COORD_W-1:0] cur_x_reg;
    logic [COORD_W-1:0] cur_y_reg;

    // Read stage.
    logic               rd_v_reg;
    logic [MEM_W-1:0]   rd_data_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    // Difference stage.
    logic               a_v_reg;
    logic [COORD_W-1:0] a_dx_reg;
    logic [COORD_W-1:0] a_dy_reg;
    logic [IDX_W-1:0]   a_idx_reg;
    logic [COORD_W-1:0] a_x_reg;
    logic [COORD_W-1:0] a_y_reg;
    // Square stage.
    logic               b_v_reg;
    logic [SQ_W-1:0]    b_sqx_reg;
    logic [SQ_W-1:0]    b_sqy_reg;
    logic [IDX_W-1:0]   b_idx_reg;
    logic [COORD_W-1:0] b_x_reg;
    logic [COORD_W-1:0] b_y_reg;
    // Best candidate.
    logic               found_reg;
    logic [DIST_W-1:0]  best_d_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic [COORD_W-1:0] best_x_reg;
    logic [COORD_W-1:0] best_y_reg;

    logic               out_valid_reg;
    out_item_t          out_item_reg;

    logic               start_new;
    logic [CNT_W-1:0]   load_base;
    logic               load_wr;
    logic [DIST_W-1:0]  dist_sum;
    logic               better;
    logic [SQ_W-1:0]    sqx;
    logic [SQ_W-1:0]    sqy;
    logic [CNT_W-1:0]   emitted_inc;
    logic [CITY_W+IDX_W-1:0] city_wide;
    logic               rd_visited;
    logic [COORD_W-1:0] rd_x;
    logic [COORD_W-1:0] rd_y;

    assign start_new   = set_complete_reg;
    assign load_base   = start_new ? '0 : point_count_reg;
    assign load_wr     = cmd.load && (start_new || (point_count_reg < CNT_W'(MAX_POINTS)));
    assign emitted_inc = emitted_reg + 1'b1;
    assign city_wide   = {{CITY_W{1'b0}}, best_idx_reg};

    assign rd_visited = rd_data_reg[MEM_W-1];
    assign rd_x       = rd_data_reg[2*COORD_W-1:COORD_W];
    assign rd_y       = rd_data_reg[COORD_W-1:0];

    assign sqx      = a_dx_reg * a_dx_reg;
    assign sqy      = a_dy_reg * a_dy_reg;
    assign dist_sum = {1'b0, b_sqx_reg} + {1'b0, b_sqy_reg};
    assign better   = b_v_reg && (!found_reg || (dist_sum < best_d_reg));

    assign status.req_ok    = set_complete_reg && (point_count_reg != '0)
                              && (emitted_reg < point_count_reg);
    assign status.first_req = (emitted_reg == '0);
    assign status.pipe_busy = rd_v_reg || a_v_reg || b_v_reg;
    assign status.out_free  = !out_valid_reg || !result_stall;

    assign point_count  = point_count_reg;
    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

    // Point store: loads clear the visited mark, a committed city sets it.
    always_ff @(posedge clk)
    begin
        if (load_wr)
        begin
            mem[load_base[IDX_W-1:0]] <= {1'b0, item.coord_x, item.coord_y};
        end
        else if (cmd.emit)
        begin
            mem[best_idx_reg] <= {1'b1, best_x_reg, best_y_reg};
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg  <= '0;
            emitted_reg      <= '0;
            set_complete_reg <= 1'b0;
            rd_v_reg         <= 1'b0;
            a_v_reg          <= 1'b0;
            b_v_reg          <= 1'b0;
            found_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                // An open set is closed by the final flag; a load on a closed set
                // starts a new one, which the same flag may close again.
                point_count_reg  <= load_wr ? (load_base + 1'b1) : load_base;
                set_complete_reg <= item.final_point;
                if (start_new)
                begin
                    emitted_reg <= '0;
                end
            end
            else if (cmd.emit)
            begin
                emitted_reg <= emitted_inc;
            end
            rd_v_reg <= cmd.rd_en;
            a_v_reg  <= rd_v_reg && !rd_visited;
            b_v_reg  <= a_v_reg;
            if (cmd.scan_clear)
            begin
                found_reg <= 1'b0;
            end
            else if (better)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_idx_reg <= rd_addr;
        end
        a_dx_reg  <= abs_diff(rd_x, cur_x_reg);
        a_dy_reg  <= abs_diff(rd_y, cur_y_reg);
        a_idx_reg <= rd_idx_reg;
        a_x_reg   <= rd_x;
        a_y_reg   <= rd_y;
        b_sqx_reg <= sqx;
        b_sqy_reg <= sqy;
        b_idx_reg <= a_idx_reg;
        b_x_reg   <= a_x_reg;
        b_y_reg   <= a_y_reg;
        if (load_wr && (load_base == '0))
        begin
            cur_x_reg <= item.coord_x;
            cur_y_reg <= item.coord_y;
        end
        else if (cmd.emit)
        begin
            cur_x_reg <= best_x_reg;
            cur_y_reg <= best_y_reg;
        end
        if (cmd.first_sel)
        begin
            best_idx_reg <= '0;
            best_x_reg   <= cur_x_reg;
            best_y_reg   <= cur_y_reg;
        end
        else if (better)
        begin
            best_d_reg   <= dist_sum;
            best_idx_reg <= b_idx_reg;
            best_x_reg   <= b_x_reg;
            best_y_reg   <= b_y_reg;
        end
        if (cmd.emit)
        begin
            out_item_reg.city     <= city_wide[CITY_W-1:0];
            out_item_reg.tour_end <= (emitted_inc == point_count_reg);
        end
    end

endmodule
